/* hdl/mnts_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mnts_pkg;

  localparam int DIGIT_W = 7;
  localparam int GRP_N   = 10;
  localparam int GRP_W   = 4;
  localparam logic [GRP_W-1:0] GRP_LAST = GRP_W'(GRP_N - 1);

  localparam logic [7:0] STATUS_OFF   = 8'h80;
  localparam logic [7:0] STATUS_ON    = 8'h90;
  localparam logic [7:0] META_PREFIX  = 8'hFF;
  localparam logic [7:0] META_EOT     = 8'h2F;
  localparam logic [7:0] BYTE_ZERO    = 8'h00;
  localparam logic [7:0] VLQ_CONT     = 8'h80;
  localparam logic [6:0] VELOCITY_RST = 7'd63;

  typedef enum logic {
    CMD_NOTE = 1'b0,
    CMD_END  = 1'b1
  } cmd_t;

  typedef enum logic {
    REG_CHANNEL  = 1'b0,
    REG_VELOCITY = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CALC,
    S_VLQ,
    S_EV0,
    S_EV1,
    S_EV2,
    S_EN0,
    S_EN1,
    S_EN2,
    S_EN3
  } state_t;

  typedef struct packed {
    logic             busy;
    logic [GRP_W-1:0] top;
  } delta_stat_t;

  typedef struct packed {
    logic        start;
    logic        clear;
    logic        first;
  } delta_ctl_t;

endpackage

`default_nettype wire

/* hdl/mnts_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface mnts_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [63:0] event_time;
  logic [6:0]  note_number;
  logic        note_on;

  modport source (output valid, cmd, event_time, note_number, note_on, input ready);
  modport sink   (input valid, cmd, event_time, note_number, note_on, output ready);
endinterface

`default_nettype wire

/* hdl/mnts_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface mnts_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        last;
  logic [31:0] track_size;

  modport source (output valid, out_byte, last, track_size, input ready);
  modport sink   (input valid, out_byte, last, track_size, output ready);
endinterface

`default_nettype wire

/* hdl/mnts_delta.sv */
`timescale 1ns / 1ps
`default_nettype none

module mnts_delta (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire mnts_pkg::delta_ctl_t              ctl,
  input  wire logic [63:0]                       time_in,
  input  wire logic [mnts_pkg::GRP_W-1:0]        grp_idx,
  output mnts_pkg::delta_stat_t                  stat,
  output logic [mnts_pkg::DIGIT_W-1:0]           grp
);
  import mnts_pkg::*;

  localparam int SR_W = GRP_N * DIGIT_W;

  logic [SR_W-1:0]    t_sr;
  logic [SR_W-1:0]    prev_sr;
  logic [DIGIT_W-1:0] d_grp [GRP_N];
  logic               borrow;
  logic               frst;
  logic               busy;
  logic [GRP_W-1:0]   cnt;
  logic [GRP_W-1:0]   top;
  logic [DIGIT_W:0]   diff;
  logic [DIGIT_W-1:0] digit;

  // 7-bit digit of t - prev, LSB first; only bit 63 survives in the top group
  always_comb begin
    diff = {1'b0, t_sr[DIGIT_W-1:0]} - {1'b0, prev_sr[DIGIT_W-1:0]}
           - {{DIGIT_W{1'b0}}, borrow};
    if (frst) begin
      digit = '0;
    end else if (cnt == GRP_LAST) begin
      digit = {{(DIGIT_W-1){1'b0}}, diff[0]};
    end else begin
      digit = diff[DIGIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      prev_sr <= '0;
      cnt     <= '0;
      top     <= '0;
    end else begin
      if (ctl.start) begin
        t_sr   <= {{(SR_W-64){1'b0}}, time_in};
        frst   <= ctl.first;
        borrow <= 1'b0;
        cnt    <= '0;
        top    <= '0;
        busy   <= 1'b1;
      end else if (busy) begin
        t_sr    <= {{DIGIT_W{1'b0}}, t_sr[SR_W-1:DIGIT_W]};
        prev_sr <= {t_sr[DIGIT_W-1:0], prev_sr[SR_W-1:DIGIT_W]};
        borrow  <= diff[DIGIT_W];
        for (int i = 0; i < GRP_N - 1; i++) begin
          d_grp[i] <= d_grp[i+1];
        end
        d_grp[GRP_N-1] <= digit;
        if (digit != '0) begin
          top <= cnt;
        end
        if (cnt == GRP_LAST) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt + GRP_W'(1);
        end
      end
      if (ctl.clear) begin
        prev_sr <= '0;
      end
    end
  end

  assign stat.busy = busy;
  assign stat.top  = top;
  assign grp       = d_grp[grp_idx];

  a_top_le_cnt: assert property (@(posedge clk) disable iff (rst)
    busy |-> (top <= cnt))
    else $error("highest nonzero group beyond current digit");

endmodule

`default_nettype wire

/* hdl/mnts_seq.sv */
`timescale 1ns / 1ps
`default_nettype none

module mnts_seq #(
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [3:0]                   channel,
  input  wire logic [6:0]                   velocity,
  mnts_in_if.sink                           in_ch,
  mnts_out_if.source                        out_ch,
  output mnts_pkg::delta_ctl_t              dctl,
  output logic [mnts_pkg::GRP_W-1:0]        grp_idx,
  input  wire mnts_pkg::delta_stat_t        dstat,
  input  wire logic [mnts_pkg::DIGIT_W-1:0] grp
);
  import mnts_pkg::*;

  state_t                 state, state_next;
  logic [GRP_W-1:0]       idx, idx_next;
  logic [6:0]             note;
  logic                   on;
  logic                   trk_start;
  logic                   ov;
  logic [7:0]             ob;
  logic                   ol;
  logic [31:0]            otl;
  logic [COUNT_WIDTH-1:0] cnt;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic                   adv;
  logic                   emit;
  logic [7:0]             ebyte;
  logic                   elast;
  logic                   eend;
  logic                   accept;

  assign adv     = !ov || out_ch.ready;
  assign cnt_inc = cnt + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
  assign accept  = in_ch.valid && in_ch.ready;

  always_comb begin
    state_next  = state;
    idx_next    = idx;
    emit        = 1'b0;
    ebyte       = BYTE_ZERO;
    elast       = 1'b0;
    eend        = 1'b0;
    in_ch.ready = 1'b0;
    dctl.start  = 1'b0;
    dctl.clear  = 1'b0;
    dctl.first  = trk_start;
    unique case (state)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          if (in_ch.cmd == CMD_END) begin
            dctl.clear = 1'b1;
            state_next = S_EN0;
          end else begin
            dctl.start = 1'b1;
            state_next = S_CALC;
          end
        end
      end
      S_CALC: begin
        if (!dstat.busy) begin
          idx_next   = dstat.top;
          state_next = S_VLQ;
        end
      end
      S_VLQ: begin
        emit  = adv;
        ebyte = (idx != '0 ? VLQ_CONT : BYTE_ZERO) | {1'b0, grp};
        if (adv) begin
          if (idx == '0) begin
            state_next = S_EV0;
          end else begin
            idx_next = idx - GRP_W'(1);
          end
        end
      end
      S_EV0: begin
        emit  = adv;
        ebyte = (on ? STATUS_ON : STATUS_OFF) | {4'h0, channel};
        if (adv) state_next = S_EV1;
      end
      S_EV1: begin
        emit  = adv;
        ebyte = {1'b0, note};
        if (adv) state_next = S_EV2;
      end
      S_EV2: begin
        emit  = adv;
        ebyte = {1'b0, velocity};
        elast = 1'b1;
        if (adv) state_next = S_IDLE;
      end
      S_EN0: begin
        emit  = adv;
        ebyte = BYTE_ZERO;
        if (adv) state_next = S_EN1;
      end
      S_EN1: begin
        emit  = adv;
        ebyte = META_PREFIX;
        if (adv) state_next = S_EN2;
      end
      S_EN2: begin
        emit  = adv;
        ebyte = META_EOT;
        if (adv) state_next = S_EN3;
      end
      S_EN3: begin
        emit  = adv;
        ebyte = BYTE_ZERO;
        elast = 1'b1;
        eend  = 1'b1;
        if (adv) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign grp_idx = idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      trk_start <= 1'b1;
      ov        <= 1'b0;
      cnt       <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (accept) begin
        trk_start <= (in_ch.cmd == CMD_END);
      end
      if (emit) begin
        ov  <= 1'b1;
        cnt <= eend ? '0 : cnt_inc;
      end else if (out_ch.ready) begin
        ov <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      note <= in_ch.note_number;
      on   <= in_ch.note_on;
    end
    if (emit) begin
      ob  <= ebyte;
      ol  <= elast;
      otl <= eend ? 32'(cnt_inc) : '0;
    end
  end

  assign out_ch.valid      = ov;
  assign out_ch.out_byte   = ob;
  assign out_ch.last       = ol;
  assign out_ch.track_size = otl;

  a_len_on_last: assert property (@(posedge clk) disable iff (rst)
    (ov && otl != '0) |-> ol)
    else $error("track length shown on a byte that is not last");

  a_note_starts_delta: assert property (@(posedge clk) disable iff (rst)
    (accept && in_ch.cmd == CMD_NOTE) |=> dstat.busy)
    else $error("note item did not start the delta unit");

  a_end_restarts: assert property (@(posedge clk) disable iff (rst)
    (emit && eend) |=> (cnt == '0 && trk_start))
    else $error("track not restarted after end of track");

endmodule

`default_nettype wire

/* hdl/midi_note_track_serializer.sv */
`timescale 1ns / 1ps
`default_nettype none

// MIDI track byte serializer. Each input item is a note event or an end of
// track; the output channel carries the track bytes of each item, with last
// set on the final byte of each input and the track byte count on the final
// byte of an end of track. The time delta is computed 7 bits per cycle by a
// serial subtractor. A note event is accepted, subtracted group by group and
// handed off, then sends its 1 to 10 delta bytes, status, note and velocity;
// an end of track sends its end event. Stalls hold both; new items wait for idle.
module midi_note_track_serializer #(
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  mnts_in_if.sink                 in_ch,
  mnts_out_if.source              out_ch,
  input  wire logic               cfg_we,
  input  wire mnts_pkg::reg_idx_t cfg_index,
  input  wire logic [6:0]         cfg_data
);
  import mnts_pkg::*;

  logic [3:0]         channel;
  logic [6:0]         velocity;
  delta_ctl_t         dctl;
  delta_stat_t        dstat;
  logic [GRP_W-1:0]   grp_idx;
  logic [DIGIT_W-1:0] grp;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel  <= '0;
      velocity <= VELOCITY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CHANNEL:  channel  <= cfg_data[3:0];
        REG_VELOCITY: velocity <= cfg_data;
        default: ;
      endcase
    end
  end

  mnts_delta u_delta (
    .clk     (clk),
    .rst     (rst),
    .ctl     (dctl),
    .time_in (in_ch.event_time),
    .grp_idx (grp_idx),
    .stat    (dstat),
    .grp     (grp)
  );

  mnts_seq #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .channel  (channel),
    .velocity (velocity),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .dctl     (dctl),
    .grp_idx  (grp_idx),
    .dstat    (dstat),
    .grp      (grp)
  );

endmodule

`default_nettype wire

/* sim/track_byte_checker.sv */
`timescale 1ns / 1ps

module track_byte_checker (
  input  logic               clk,
  input  logic               rst,
  mnts_in_if                 in_ch,
  mnts_out_if                out_ch,
  input  logic               cfg_we,
  input  mnts_pkg::reg_idx_t cfg_index,
  input  logic [6:0]         cfg_data,
  output int                 errors,
  output int                 pending
);
  import mnts_pkg::*;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [31:0] total;
  } track_byte_t;

  track_byte_t expected_q[$];

  logic [63:0] prev_time;
  logic        fresh;
  logic [31:0] byte_total;
  logic [3:0]  chan;
  logic [6:0]  vel;

  task automatic mismatch(input string msg);
    errors++;
    if (errors <= 50) $display("[%0t] track byte mismatch: %s", $time, msg);
  endtask

  task automatic push_byte(input logic [7:0] d, input logic l, input logic [31:0] n);
    expected_q.push_back('{data: d, last: l, total: n});
  endtask

  task automatic predict_event(input cmd_t cmd, input logic [63:0] t,
                               input logic [6:0] note, input logic on);
    logic [63:0] delta;
    logic [6:0]  digits [10];
    int          n;
    if (cmd == CMD_NOTE) begin
      delta = fresh ? 64'd0 : t - prev_time;
      prev_time = t;
      fresh = 1'b0;
      n = 0;
      do begin
        digits[n] = delta[6:0];
        delta = delta >> 7;
        n++;
      end while (delta != 0);
      for (int i = n - 1; i >= 0; i--) push_byte({i > 0, digits[i]}, 1'b0, '0);
      push_byte((on ? STATUS_ON : STATUS_OFF) | {4'h0, chan}, 1'b0, '0);
      push_byte({1'b0, note}, 1'b0, '0);
      push_byte({1'b0, vel}, 1'b1, '0);
      byte_total = byte_total + 32'(n + 3);
    end else begin
      byte_total = byte_total + 32'd4;
      push_byte(BYTE_ZERO, 1'b0, '0);
      push_byte(META_PREFIX, 1'b0, '0);
      push_byte(META_EOT, 1'b0, '0);
      push_byte(BYTE_ZERO, 1'b1, byte_total);
      prev_time = '0;
      fresh = 1'b1;
      byte_total = '0;
    end
  endtask

  always @(posedge clk) begin
    track_byte_t want;
    if (rst) begin
      prev_time = '0;
      fresh = 1'b1;
      byte_total = '0;
      chan = '0;
      vel = VELOCITY_RST;
      expected_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          mismatch($sformatf("unexpected byte %02h", out_ch.out_byte));
        end else begin
          want = expected_q.pop_front();
          if (out_ch.out_byte !== want.data)
            mismatch($sformatf("out_byte %02h, want %02h", out_ch.out_byte, want.data));
          if (out_ch.last !== want.last)
            mismatch($sformatf("last %b, want %b (byte %02h)", out_ch.last, want.last,
                               want.data));
          if (out_ch.track_size !== want.total)
            mismatch($sformatf("track_size %0d, want %0d", out_ch.track_size,
                               want.total));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_CHANNEL: chan = cfg_data[3:0];
          REG_VELOCITY: vel = cfg_data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        predict_event(cmd_t'(in_ch.cmd), in_ch.event_time, in_ch.note_number, in_ch.note_on);
    end
    pending = expected_q.size();
  end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
  import mnts_pkg::*;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  reg_idx_t   cfg_index;
  logic [6:0] cfg_data;
  int         errors;
  int         pending;
  bit         no_gaps = 1'b0;
  int         sink_hold = 0;

  mnts_in_if  in_ch ();
  mnts_out_if out_ch ();

  midi_note_track_serializer #(.COUNT_WIDTH(32)) dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  track_byte_checker chk (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .errors(errors),
    .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("midi_note_track_serializer verification failed");
    $finish;
  end

  // byte sink: random stall per item, one long hold when requested
  initial begin
    int gap;
    bit held;
    held = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      gap = no_gaps ? 0 : $urandom_range(0, 16);
      if (sink_hold > 0 && !held) begin
        gap = sink_hold;
        held = 1'b1;
      end
      @(negedge clk);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  task automatic offer_event(input cmd_t c, input logic [63:0] t,
                             input logic [6:0] note, input logic on);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 16);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= c;
    in_ch.event_time <= t;
    in_ch.note_number <= note;
    in_ch.note_on <= on;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic wait_drained(input int tail);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (tail) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [6:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [63:0] t;
    int          len;
    int          kind;
    int          sent;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_CHANNEL;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_NOTE;
    in_ch.event_time = '0;
    in_ch.note_number = '0;
    in_ch.note_on = 1'b0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // reset register values, empty track, delta encodings of one, two, three and ten bytes
    offer_event(CMD_END, '1, 7'h7F, 1'b1);
    offer_event(CMD_NOTE, '1, 7'h7F, 1'b1);
    offer_event(CMD_NOTE, '0, 7'h00, 1'b0);
    t = 64'd127;
    offer_event(CMD_NOTE, t, 7'h2A, 1'b1);
    t = t + 64'd128;
    offer_event(CMD_NOTE, t, 7'h55, 1'b0);
    t = t + 64'd16383;
    offer_event(CMD_NOTE, t, 7'h01, 1'b1);
    t = t + 64'd16384;
    offer_event(CMD_NOTE, t, 7'h7E, 1'b0);
    offer_event(CMD_NOTE, t, 7'h40, 1'b1);
    t = t - 64'd1;
    offer_event(CMD_NOTE, t, 7'h3C, 1'b0);
    t = t + 64'h8000_0000_0000_0000;
    offer_event(CMD_NOTE, t, 7'h3D, 1'b1);
    offer_event(CMD_END, 64'h5555_AAAA_5555_AAAA, 7'h2B, 1'b0);
    wait_drained(8);

    write_reg(REG_CHANNEL, 7'd15);
    write_reg(REG_VELOCITY, 7'd0);
    t = 64'd12345;
    offer_event(CMD_NOTE, t, 7'd60, 1'b1);
    t = t + 64'h0100_0000_0000_0000;
    offer_event(CMD_NOTE, t, 7'd60, 1'b0);
    t = t + 64'h0001_FFFF_FFFF_FFFF;
    offer_event(CMD_NOTE, t, 7'd127, 1'b0);
    offer_event(CMD_END, '0, 7'd0, 1'b1);
    wait_drained(8);

    write_reg(REG_CHANNEL, 7'd0);
    write_reg(REG_VELOCITY, 7'd127);
    offer_event(CMD_NOTE, 64'd5, 7'd1, 1'b1);
    offer_event(CMD_NOTE, 64'd0, 7'd2, 1'b0);
    offer_event(CMD_END, '1, 7'd3, 1'b1);
    wait_drained(8);

    for (int p = 0; p < 6; p++) begin
      if (p == 0) begin
        write_reg(REG_CHANNEL, 7'd15);
        write_reg(REG_VELOCITY, 7'd0);
      end else if (p == 5) begin
        write_reg(REG_CHANNEL, 7'd0);
        write_reg(REG_VELOCITY, 7'd127);
      end else begin
        write_reg(REG_CHANNEL, 7'($urandom_range(0, 15)));
        write_reg(REG_VELOCITY, 7'($urandom_range(0, 127)));
      end
      if (p == 2) begin
        no_gaps = 1'b1;
        sink_hold = 300;
        for (int k = 0; k < 16; k++) begin
          t = t + 64'($urandom_range(0, 300));
          offer_event(CMD_NOTE, t, 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
        end
        offer_event(CMD_END, {$urandom, $urandom}, 7'($urandom_range(0, 127)), 1'b0);
      end
      sent = 0;
      while (sent < 27) begin
        no_gaps = ($urandom_range(0, 3) == 0);
        len = $urandom_range(0, 8);
        if ($urandom_range(0, 1) == 0) t = {$urandom, $urandom};
        for (int k = 0; k < len; k++) begin
          kind = $urandom_range(0, 19);
          if (kind == 0)
            t = {$urandom, $urandom};
          else if (kind == 1)
            t = t - 64'($urandom_range(1, 1000));
          else if (kind <= 4)
            t = t + ({$urandom, $urandom} >> $urandom_range(0, 63));
          else
            t = t + (64'($urandom_range(0, 255)) << (7 * $urandom_range(0, 2)));
          offer_event(CMD_NOTE, t, 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
          sent++;
        end
        if ($urandom_range(0, 9) != 0) begin
          offer_event(CMD_END, {$urandom, $urandom}, 7'($urandom_range(0, 127)),
                      1'($urandom_range(0, 1)));
          sent++;
        end
      end
      no_gaps = 1'b0;
      wait_drained(8);
    end

    wait_drained(30);
    if (errors == 0 && pending == 0)
      $display("midi_note_track_serializer verification clean");
    else
      $display("midi_note_track_serializer verification failed");
    $finish;
  end

endmodule
